/* src/pqp_pkg.sv */
// Shared constants, widths and types of the quantum parameter pipeline.
package pqp_pkg;

  // Field width of the E and B inputs (24 to 48)
  localparam int FIELD_WIDTH = 32;

  localparam int MOM_W   = 32;
  localparam int GAMMA_W = 31;
  localparam int CM_W    = 32;
  localparam int INV_W   = 48;
  localparam int CHI_W   = 32;
  localparam int CHI_SHIFT = 80;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  // Front end widths
  localparam int PROD_W   = FIELD_WIDTH + MOM_W;
  localparam int TERM_W   = PROD_W + 2;
  localparam int MAG_W    = TERM_W;
  localparam int SPLIT_LO = (MAG_W + 1) / 2;
  localparam int SPLIT_HI = MAG_W - SPLIT_LO;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int S_W      = SQ_W + 2;
  localparam int FRONT_STAGES = 7;

  // Square root widths
  localparam int ROOT_W = S_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Scaling widths
  localparam int R_LO  = (ROOT_W + 1) / 2;
  localparam int R_HI  = ROOT_W - R_LO;
  localparam int P1_W  = ROOT_W + CM_W;
  localparam int C_W   = (P1_W + 2) / 3;
  localparam int C_TOP = P1_W - 2 * C_W;
  localparam int I_LO  = INV_W / 2;
  localparam int I_HI  = INV_W - I_LO;
  localparam int Q_W   = C_W + I_HI;
  localparam int X_W   = P1_W + INV_W;
  localparam int SCALE_STAGES = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_OVER_MASS_SQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCHWINGER_FIELD = CFG_IDX_W'(1);

  // Reset values (charge stored as magnitude)
  localparam logic [CM_W-1:0]  CMAG_RESET = CM_W'(65536);
  localparam logic [INV_W-1:0] INV_RESET  = INV_W'(686799000);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [SQ_W-1:0]          sq_t;
  typedef logic signed [S_W-1:0]    s_t;
  typedef logic [S_W-1:0]           smag_t;
  typedef logic [ROOT_W-1:0]        root_t;
  typedef logic [REM_W-1:0]         rem_t;

  typedef struct packed {
    logic signed [MOM_W-1:0]       mom_x;
    logic signed [MOM_W-1:0]       mom_y;
    logic signed [MOM_W-1:0]       mom_z;
    logic [GAMMA_W-1:0]            lorentz_factor;
    logic signed [FIELD_WIDTH-1:0] efield_x;
    logic signed [FIELD_WIDTH-1:0] efield_y;
    logic signed [FIELD_WIDTH-1:0] efield_z;
    logic signed [FIELD_WIDTH-1:0] bfield_x;
    logic signed [FIELD_WIDTH-1:0] bfield_y;
    logic signed [FIELD_WIDTH-1:0] bfield_z;
  } item_t;

endpackage

/* src/pqp_ifs.sv */
// Valid/ready channel interfaces for particle items and chi results.
interface pqp_item_if;
  import pqp_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [MOM_W-1:0]       mom_x;
  logic signed [MOM_W-1:0]       mom_y;
  logic signed [MOM_W-1:0]       mom_z;
  logic [GAMMA_W-1:0]            lorentz_factor;
  logic signed [FIELD_WIDTH-1:0] efield_x;
  logic signed [FIELD_WIDTH-1:0] efield_y;
  logic signed [FIELD_WIDTH-1:0] efield_z;
  logic signed [FIELD_WIDTH-1:0] bfield_x;
  logic signed [FIELD_WIDTH-1:0] bfield_y;
  logic signed [FIELD_WIDTH-1:0] bfield_z;
  modport source (output valid, mom_x, mom_y, mom_z, lorentz_factor, efield_x, efield_y,
                  efield_z, bfield_x, bfield_y, bfield_z, input ready);
  modport sink (input valid, mom_x, mom_y, mom_z, lorentz_factor, efield_x, efield_y,
                efield_z, bfield_x, bfield_y, bfield_z, output ready);
endinterface

interface pqp_result_if;
  import pqp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CHI_W-1:0] chi_value;
  logic             chi_saturated;
  modport source (output valid, chi_value, chi_saturated, input ready);
  modport sink (input valid, chi_value, chi_saturated, output ready);
endinterface

/* src/pqp_front.sv */
// Products, field sums, exact squares and magnitude of the invariant.
module pqp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pqp_pkg::item_t item,
  output logic           out_valid,
  output pqp_pkg::smag_t smag
);
  import pqp_pkg::*;

  logic [FRONT_STAGES-1:0] vld;
  prod_t pr [12];
  term_t tm [4];
  mag_t  mg [4];
  logic [2*SPLIT_LO-1:0]       pll [4];
  logic [SPLIT_LO+SPLIT_HI-1:0] plh [4];
  logic [2*SPLIT_HI-1:0]       phh [4];
  sq_t   sq [4];
  s_t    s;
  logic signed [MOM_W-1:0] g_s;

  assign g_s = $signed({1'b0, item.lorentz_factor});

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: the twelve products
      pr[0]  <= item.efield_x * item.mom_x;
      pr[1]  <= item.efield_y * item.mom_y;
      pr[2]  <= item.efield_z * item.mom_z;
      pr[3]  <= g_s * item.efield_x;
      pr[4]  <= item.bfield_y * item.mom_z;
      pr[5]  <= item.bfield_z * item.mom_y;
      pr[6]  <= g_s * item.efield_y;
      pr[7]  <= item.bfield_z * item.mom_x;
      pr[8]  <= item.bfield_x * item.mom_z;
      pr[9]  <= g_s * item.efield_z;
      pr[10] <= item.bfield_x * item.mom_y;
      pr[11] <= item.bfield_y * item.mom_x;
      // stage 2: E.p and the three components
      tm[0] <= term_t'(pr[0]) + term_t'(pr[1]) + term_t'(pr[2]);
      tm[1] <= term_t'(pr[3]) - term_t'(pr[4]) + term_t'(pr[5]);
      tm[2] <= term_t'(pr[6]) - term_t'(pr[7]) + term_t'(pr[8]);
      tm[3] <= term_t'(pr[9]) - term_t'(pr[10]) + term_t'(pr[11]);
      for (int i = 0; i < 4; i++) begin
        // stage 3: magnitudes
        mg[i]  <= tm[i][TERM_W-1] ? MAG_W'(-tm[i]) : MAG_W'(tm[i]);
        // stage 4: partial products of the squares
        pll[i] <= mg[i][SPLIT_LO-1:0] * mg[i][SPLIT_LO-1:0];
        plh[i] <= mg[i][SPLIT_LO-1:0] * mg[i][MAG_W-1:SPLIT_LO];
        phh[i] <= mg[i][MAG_W-1:SPLIT_LO] * mg[i][MAG_W-1:SPLIT_LO];
        // stage 5: squares
        sq[i]  <= (SQ_W'(phh[i]) << (2 * SPLIT_LO)) + (SQ_W'(plh[i]) << (SPLIT_LO + 1))
                  + SQ_W'(pll[i]);
      end
      // stage 6: invariant
      s <= $signed({2'b00, sq[0]}) - $signed({2'b00, sq[1]})
           - $signed({2'b00, sq[2]}) - $signed({2'b00, sq[3]});
      // stage 7: its magnitude
      smag <= s[S_W-1] ? smag_t'(-s) : smag_t'(s);
    end
  end

  assign out_valid = vld[FRONT_STAGES-1];

endmodule

/* src/pqp_sqrt.sv */
// Truncated square root, one result bit per pipeline stage.
module pqp_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  pqp_pkg::smag_t rad,
  output logic           out_valid,
  output pqp_pkg::root_t root
);
  import pqp_pkg::*;

  logic [ROOT_W-1:0] vld;
  smag_t rad_q  [ROOT_W];
  rem_t  rem_q  [ROOT_W];
  root_t root_q [ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    smag_t rad_in;
    rem_t  rem_in;
    root_t root_in;
    rem_t  rem_sh;
    rem_t  trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[S_W-1:S_W-2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_q[k] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];

endmodule

/* src/pqp_scale.sv */
// Scaling of the root by |q/m^2| and the inverse field, then saturation.
module pqp_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  pqp_pkg::root_t              root,
  input  logic [pqp_pkg::CM_W-1:0]    cmag,
  input  logic [pqp_pkg::INV_W-1:0]   inv,
  output logic                        out_valid,
  output logic [pqp_pkg::CHI_W-1:0]   chi,
  output logic                        sat
);
  import pqp_pkg::*;

  logic [SCALE_STAGES-1:0] vld;
  logic [R_LO+CM_W-1:0] pa;
  logic [R_HI+CM_W-1:0] pb;
  logic [P1_W-1:0]      p1;
  logic [C_W-1:0]       ch [3];
  logic [Q_W-1:0]       q  [6];
  logic [X_W-1:0]       x;
  logic                 over;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SCALE_STAGES-2:0], in_valid};
    end
  end

  // chunks of the first product
  assign ch[0] = p1[C_W-1:0];
  assign ch[1] = p1[2*C_W-1:C_W];
  assign ch[2] = C_W'(p1[P1_W-1:2*C_W]);
  assign over  = |x[X_W-1:CHI_SHIFT+CHI_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: root halves times charge magnitude
      pa <= root[R_LO-1:0] * cmag;
      pb <= root[ROOT_W-1:R_LO] * cmag;
      // stage 2: combine
      p1 <= (P1_W'(pb) << R_LO) + P1_W'(pa);
      // stage 3: six partial products with the inverse field, full width
      for (int i = 0; i < 3; i++) begin
        q[2*i]   <= ch[i] * inv[I_LO-1:0];
        q[2*i+1] <= ch[i] * inv[INV_W-1:I_LO];
      end
      // stage 4: sum of partials
      x <= X_W'(q[0]) + (X_W'(q[1]) << I_LO)
           + (X_W'(q[2]) << C_W) + (X_W'(q[3]) << (C_W + I_LO))
           + (X_W'(q[4]) << (2 * C_W)) + (X_W'(q[5]) << (2 * C_W + I_LO));
      // stage 5: truncate to Q16.16, saturate
      sat <= over;
      chi <= over ? '1 : x[CHI_SHIFT +: CHI_W];
    end
  end

  assign out_valid = vld[SCALE_STAGES-1];

endmodule

/* src/particle_quantum_parameter.sv */
// Quantum parameter chi pipeline: one particle item per cycle, one result each.
// The pipeline has 7 front stages, ROOT_W root stages and 5 scaling stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Every stage carries its own valid bit; the last stage is the output register.
// Reset (synchronous, active high) empties the pipeline and restores both registers.
module particle_quantum_parameter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pqp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pqp_pkg::CFG_DATA_W-1:0]    cfg_data,
  pqp_item_if.sink                          item_in,
  pqp_result_if.source                      result_out
);
  import pqp_pkg::*;

  logic [CM_W-1:0]  cmag;
  logic [INV_W-1:0] inv;
  logic             adv;
  item_t            item;
  logic             front_valid;
  smag_t            smag;
  logic             root_valid;
  root_t            root;
  logic [CM_W-1:0]  cm_raw;

  // pipeline advances unless a result is stuck at the output
  assign adv           = !result_out.valid || result_out.ready;
  assign item_in.ready = adv;

  assign item = '{mom_x: item_in.mom_x, mom_y: item_in.mom_y, mom_z: item_in.mom_z,
                  lorentz_factor: item_in.lorentz_factor,
                  efield_x: item_in.efield_x, efield_y: item_in.efield_y,
                  efield_z: item_in.efield_z, bfield_x: item_in.bfield_x,
                  bfield_y: item_in.bfield_y, bfield_z: item_in.bfield_z};

  // config registers; charge kept as its magnitude
  assign cm_raw = cfg_data[CM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cmag <= CMAG_RESET;
      inv  <= INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHARGE_OVER_MASS_SQ: cmag <= cm_raw[CM_W-1] ? -cm_raw : cm_raw;
        CFG_INV_SCHWINGER_FIELD: inv  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  pqp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (item_in.valid),
    .item      (item),
    .out_valid (front_valid),
    .smag      (smag)
  );

  pqp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .rad       (smag),
    .out_valid (root_valid),
    .root      (root)
  );

  pqp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (root_valid),
    .root      (root),
    .cmag      (cmag),
    .inv       (inv),
    .out_valid (result_out.valid),
    .chi       (result_out.chi_value),
    .sat       (result_out.chi_saturated)
  );

endmodule
